[rtl/iokb_pkg.sv]
// ---------------------------------------------------------------------------
// iokb_pkg: shared types and constants of the I/O port block
// Request and response payload types, command codes, port decode constants,
// the beeper level lookup and the keyboard column mask.
// ---------------------------------------------------------------------------
package iokb_pkg;

   // Command codes of a request
   localparam logic [1:0] CMD_WRITE    = 2'd0;
   localparam logic [1:0] CMD_READ     = 2'd1;
   localparam logic [1:0] CMD_KEY_DOWN = 2'd2;
   localparam logic [1:0] CMD_KEY_UP   = 2'd3;

   // Port decoding
   localparam logic [15:0] PAGING_DECODE_MASK = 16'h8002;
   localparam logic [7:0]  PORT_KEYS          = 8'hFE;
   localparam logic [7:0]  PORT_FF            = 8'hFF;

   // Keyboard matrix
   localparam int         NUM_ROWS  = 8;
   localparam int         ROW_BITS  = 5;
   localparam logic [4:0] ROW_ALL   = 5'h1F;

   // Beeper levels
   localparam logic signed [15:0] LEVEL_BASE = 16'sd16384;
   localparam logic signed [15:0] LEVEL_STEP = 16'sd8192;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] address;
      logic [7:0]  write_value;
      logic [2:0]  key_row;
      logic [2:0]  key_column;
      logic        tape_ear;
   } req_type;

   typedef struct packed {
      logic [7:0]         read_data;
      logic signed [15:0] beeper_level;
      logic               level_update;
      logic [7:0]         paging_latch;
   } rsp_type;

   // Map FE latch bits 4:3 to the audio level
   function automatic logic signed [15:0] beeper_lookup(input logic [1:0] sel);
      logic signed [15:0] level;
      unique case (sel)
         2'd0:    level = -(LEVEL_BASE + LEVEL_STEP);
         2'd1:    level = -LEVEL_BASE;
         2'd2:    level = LEVEL_BASE;
         default: level = LEVEL_BASE + LEVEL_STEP;
      endcase
      return level;
   endfunction

   // One-hot column mask; columns beyond the row width select nothing
   function automatic logic [4:0] column_mask(input logic [2:0] col);
      logic [4:0] mask;
      case (col)
         3'd0:    mask = 5'b00001;
         3'd1:    mask = 5'b00010;
         3'd2:    mask = 5'b00100;
         3'd3:    mask = 5'b01000;
         3'd4:    mask = 5'b10000;
         default: mask = 5'b00000;
      endcase
      return mask;
   endfunction

endpackage

[rtl/iokb_req_if.sv]
// ---------------------------------------------------------------------------
// iokb_req_if: request channel
// Valid/ready channel carrying one bus access or key event.
// ---------------------------------------------------------------------------
interface iokb_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [15:0] address;
   logic [7:0]  write_value;
   logic [2:0]  key_row;
   logic [2:0]  key_column;
   logic        tape_ear;

   modport source (
      output valid, cmd, address, write_value, key_row, key_column, tape_ear,
      input  ready
   );

   modport sink (
      input  valid, cmd, address, write_value, key_row, key_column, tape_ear,
      output ready
   );
endinterface

[rtl/iokb_rsp_if.sv]
// ---------------------------------------------------------------------------
// iokb_rsp_if: response channel
// Valid/ready channel carrying one response per request.
// ---------------------------------------------------------------------------
interface iokb_rsp_if;
   logic               valid;
   logic               ready;
   logic [7:0]         read_data;
   logic signed [15:0] beeper_level;
   logic               level_update;
   logic [7:0]         paging_latch;

   modport source (
      output valid, read_data, beeper_level, level_update, paging_latch,
      input  ready
   );

   modport sink (
      input  valid, read_data, beeper_level, level_update, paging_latch,
      output ready
   );
endinterface

[rtl/io_port_keyboard_beeper.sv]
// ---------------------------------------------------------------------------
// io_port_keyboard_beeper: home-computer I/O port block
// Port write decoding (FE, FF and paging latches), keyboard matrix reads,
// key press/release tracking and beeper level selection.
// ---------------------------------------------------------------------------
// Usage:
//   req_ch carries one request: a bus write, a bus read, a key down or a
//   key up. Each accepted request yields exactly one response on rsp_ch,
//   in order: read data (0 for non-reads), the beeper level after the
//   request, a flag set when the request wrote the FE latch, and the
//   paging latch after the request.
//   A request is captured in the request register, decoded against the
//   latches and the eight keyboard rows, and lands in the response
//   register once that register is free or being emptied. One request per
//   cycle is sustained while the receiver does not stall, through the
//   single decode stage between the request register and the response
//   register.
//   Reset (synchronous, active high) releases all keys, clears the three
//   latches and empties both registers.
//   When the receiver stalls, the response register holds; the request
//   register still takes one more request, then req_ch.ready drops until
//   the response is taken.
// ---------------------------------------------------------------------------
module io_port_keyboard_beeper (
   input logic        clock,
   input logic        reset,
   iokb_req_if.sink   req_ch,
   iokb_rsp_if.source rsp_ch
);
   import iokb_pkg::*;

   // Request register
   logic    s1_valid_ff, s1_valid_in;
   req_type s1_ff;
   logic    s1_advance;

   // Response register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // Architectural state
   logic [ROW_BITS-1:0] key_rows_ff [NUM_ROWS];
   logic [ROW_BITS-1:0] key_rows_in [NUM_ROWS];
   logic [7:0] fe_latch_ff, fe_latch_in;
   logic [7:0] ff_latch_ff, ff_latch_in;
   logic [7:0] fd_latch_ff, fd_latch_in;

   // Decode scratch
   logic [ROW_BITS-1:0] keys;
   logic [ROW_BITS-1:0] col_mask;
   logic [ROW_BITS-1:0] row_sel;
   logic [7:0]          rdata;
   logic                updated;

   // Handshake: stage moves when the response slot is free or being emptied
   assign s1_advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s1_advance;
   assign s1_valid_in  = req_ch.ready ? req_ch.valid : s1_valid_ff;
   assign rsp_valid_in = s1_advance || (rsp_valid_ff && !rsp_ch.ready);

   // Capture the request
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_ch.valid && req_ch.ready) begin
         s1_ff.cmd         <= req_ch.cmd;
         s1_ff.address     <= req_ch.address;
         s1_ff.write_value <= req_ch.write_value;
         s1_ff.key_row     <= req_ch.key_row;
         s1_ff.key_column  <= req_ch.key_column;
         s1_ff.tape_ear    <= req_ch.tape_ear;
      end
   end

   // Keyboard byte: AND every row whose select bit is low
   always_comb begin
      keys = ROW_ALL;
      for (int i = 0; i < NUM_ROWS; i++) begin
         if (!s1_ff.address[8+i]) begin
            keys = keys & key_rows_ff[3'(NUM_ROWS - 1 - i)];
         end
      end
   end

   assign col_mask = column_mask(s1_ff.key_column);
   assign row_sel  = key_rows_ff[s1_ff.key_row];

   // Decode the request and compute next state
   always_comb begin
      fe_latch_in = fe_latch_ff;
      ff_latch_in = ff_latch_ff;
      fd_latch_in = fd_latch_ff;
      key_rows_in = key_rows_ff;
      rdata       = 8'd0;
      updated     = 1'b0;
      unique case (s1_ff.cmd)
         CMD_WRITE: begin
            if (s1_ff.address[0]) begin
               if ((s1_ff.address & PAGING_DECODE_MASK) == 16'd0) begin
                  fd_latch_in = s1_ff.write_value;
               end else if (s1_ff.address[7:0] == PORT_FF) begin
                  ff_latch_in = s1_ff.write_value;
               end
            end else begin
               fe_latch_in = s1_ff.write_value;
               updated     = 1'b1;
            end
         end
         CMD_READ: begin
            if (s1_ff.address[7:0] == PORT_KEYS) begin
               rdata = {1'b0, s1_ff.tape_ear, 1'b0, keys};
            end else if (s1_ff.address[7:0] == PORT_FF) begin
               rdata = ff_latch_ff;
            end
         end
         CMD_KEY_DOWN: begin
            key_rows_in[s1_ff.key_row] = row_sel & ~col_mask;
         end
         default: begin
            key_rows_in[s1_ff.key_row] = row_sel | col_mask;
         end
      endcase
      rsp_in.read_data    = rdata;
      rsp_in.beeper_level = beeper_lookup(fe_latch_in[4:3]);
      rsp_in.level_update = updated;
      rsp_in.paging_latch = fd_latch_in;
   end

   // Commit state and load the response
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         fe_latch_ff  <= 8'd0;
         ff_latch_ff  <= 8'd0;
         fd_latch_ff  <= 8'd0;
         for (int r = 0; r < NUM_ROWS; r++) begin
            key_rows_ff[r] <= ROW_ALL;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (s1_advance) begin
            fe_latch_ff <= fe_latch_in;
            ff_latch_ff <= ff_latch_in;
            fd_latch_ff <= fd_latch_in;
            key_rows_ff <= key_rows_in;
         end
      end
      if (s1_advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // Drive the response channel
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.read_data    = rsp_ff.read_data;
   assign rsp_ch.beeper_level = rsp_ff.beeper_level;
   assign rsp_ch.level_update = rsp_ff.level_update;
   assign rsp_ch.paging_latch = rsp_ff.paging_latch;

   // A request accepted while the stage is full must coincide with its drain
   assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && s1_valid_ff) |-> s1_advance)
      else $error("request accepted over an undrained stage");

   // Only a write may flag a level update
   assert property (@(posedge clock) disable iff (reset)
      (s1_advance && s1_ff.cmd != CMD_WRITE) |=> !rsp_ff.level_update)
      else $error("level update flagged for a non-write request");

   // Non-read requests return zero data
   assert property (@(posedge clock) disable iff (reset)
      (s1_advance && s1_ff.cmd != CMD_READ) |=> (rsp_ff.read_data == 8'd0))
      else $error("non-read request returned data");

   // The paging and FE latches change only when a request is committed
   assert property (@(posedge clock) disable iff (reset)
      !s1_advance |=> ($stable(fd_latch_ff) && $stable(fe_latch_ff)))
      else $error("latch changed without a committed request");

   // The response reports the paging latch as committed
   assert property (@(posedge clock) disable iff (reset)
      s1_advance |=> (rsp_ff.paging_latch == fd_latch_ff))
      else $error("response paging latch mismatch");

endmodule

[sim/io_port_keyboard_beeper_checker.sv]
// ---------------------------------------------------------------------------
// io_port_keyboard_beeper_checker: response predictor and scoreboard
// Watches the request and response channels of the I/O port block. Every
// accepted request is run through a local model of the latches and the
// keyboard matrix, and the predicted response is queued. Every accepted
// response is compared field by field with the oldest queued prediction.
// ---------------------------------------------------------------------------
module io_port_keyboard_beeper_checker
   import iokb_pkg::*;
(
   input  logic clock,
   input  logic reset,
   iokb_req_if  req_mon,
   iokb_rsp_if  rsp_mon,
   output int   fail_count,
   output int   pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_CAP = 100;

   // Local copy of the block state
   logic [4:0] key_state [NUM_ROWS];
   logic [7:0] fe_shadow;
   logic [7:0] ff_shadow;
   logic [7:0] fd_shadow;

   rsp_type predicted_rsps [$];

   initial fail_count = 0;
   initial pending_count = 0;

   // Print one line per mismatch (up to a cap) and count it
   task automatic report_mismatch(input string what);
      if (fail_count < REPORT_CAP) begin
         $display("[%0t] mismatch: %s", $time, what);
      end
      fail_count++;
   endtask

   // Apply one request to the local state and return the response it yields
   function automatic rsp_type apply_request(input req_type r);
      rsp_type    rsp;
      logic [4:0] keys;
      logic [4:0] colbit;
      logic [1:0] sel;
      rsp = '0;
      colbit = (r.key_column < 3'd5) ? 5'(5'd1 << r.key_column) : 5'd0;
      case (r.cmd)
         CMD_WRITE: begin
            if (r.address[0]) begin
               if ((r.address & PAGING_DECODE_MASK) == 16'd0) begin
                  fd_shadow = r.write_value;
               end else if (r.address[7:0] == PORT_FF) begin
                  ff_shadow = r.write_value;
               end
            end else begin
               fe_shadow = r.write_value;
               rsp.level_update = 1'b1;
            end
         end
         CMD_READ: begin
            if (r.address[7:0] == PORT_KEYS) begin
               // AND in row 7-b for every high address bit b that is low
               keys = ROW_ALL;
               for (int b = 0; b < NUM_ROWS; b++) begin
                  if (!r.address[8 + b]) keys &= key_state[NUM_ROWS - 1 - b];
               end
               rsp.read_data = {1'b0, r.tape_ear, 1'b0, keys};
            end else if (r.address[7:0] == PORT_FF) begin
               rsp.read_data = ff_shadow;
            end
         end
         CMD_KEY_DOWN: key_state[r.key_row] = key_state[r.key_row] & ~colbit;
         CMD_KEY_UP:   key_state[r.key_row] = key_state[r.key_row] | colbit;
         default: ;
      endcase
      // Sign from bit 4; the outer levels add one step to the base
      sel = fe_shadow[4:3];
      rsp.beeper_level = LEVEL_BASE + ((sel[1] == sel[0]) ? LEVEL_STEP : 16'sd0);
      if (!sel[1]) rsp.beeper_level = -rsp.beeper_level;
      rsp.paging_latch = fd_shadow;
      return rsp;
   endfunction

   // Score responses first, then queue the prediction for a new request
   always @(posedge clock) begin
      rsp_type want;
      req_type seen;
      if (reset) begin
         for (int i = 0; i < NUM_ROWS; i++) key_state[i] = ROW_ALL;
         fe_shadow = '0;
         ff_shadow = '0;
         fd_shadow = '0;
         predicted_rsps.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (predicted_rsps.size() == 0) begin
               report_mismatch($sformatf("response with nothing outstanding, read_data %02h",
                                         rsp_mon.read_data));
            end else begin
               want = predicted_rsps.pop_front();
               if (rsp_mon.read_data !== want.read_data)
                  report_mismatch($sformatf("read_data got %02h want %02h",
                                            rsp_mon.read_data, want.read_data));
               if (rsp_mon.beeper_level !== want.beeper_level)
                  report_mismatch($sformatf("beeper_level got %0d want %0d",
                                            rsp_mon.beeper_level, want.beeper_level));
               if (rsp_mon.level_update !== want.level_update)
                  report_mismatch($sformatf("level_update got %b want %b",
                                            rsp_mon.level_update, want.level_update));
               if (rsp_mon.paging_latch !== want.paging_latch)
                  report_mismatch($sformatf("paging_latch got %02h want %02h",
                                            rsp_mon.paging_latch, want.paging_latch));
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            seen.cmd         = req_mon.cmd;
            seen.address     = req_mon.address;
            seen.write_value = req_mon.write_value;
            seen.key_row     = req_mon.key_row;
            seen.key_column  = req_mon.key_column;
            seen.tape_ear    = req_mon.tape_ear;
            predicted_rsps.push_back(apply_request(seen));
         end
      end
      pending_count <= predicted_rsps.size();
   end

endmodule

[sim/io_port_keyboard_beeper_tb.sv]
// ---------------------------------------------------------------------------
// io_port_keyboard_beeper_tb: testbench top of the I/O port block
// Drives a directed set of port accesses and key events, then random
// traffic in phases with sender gaps and receiver stalls, including a long
// receiver hold-off that backs up the block. Scoring is done by the checker.
// ---------------------------------------------------------------------------
module io_port_keyboard_beeper_tb;
   import iokb_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RESET_CYCLES    = 10;
   localparam int NUM_PHASES      = 4;
   localparam int ITEMS_PER_PHASE = 306;
   localparam int HOLDOFF_CYCLES  = 200;
   localparam int DRAIN_CYCLES    = 10;
   localparam int WATCHDOG_LIMIT  = 2000;

   // Sender idle and receiver stall percentages per phase
   localparam int SEND_IDLE_PCT [NUM_PHASES] = '{0, 76, 0, 9};
   localparam int RSP_STALL_PCT [NUM_PHASES] = '{0, 0, 76, 9};

   logic clock = 1'b0;
   logic reset = 1'b1;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int holdoff_seq   = 0;
   int stall_cycles  = 0;
   int fail_count;
   int pending_count;

   iokb_req_if req_ch ();
   iokb_rsp_if rsp_ch ();

   io_port_keyboard_beeper u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   io_port_keyboard_beeper_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always #6 clock = ~clock;

   // Hold inputs known until the first edge
   initial begin
      req_ch.valid       = 1'b0;
      req_ch.cmd         = CMD_WRITE;
      req_ch.address     = '0;
      req_ch.write_value = '0;
      req_ch.key_row     = '0;
      req_ch.key_column  = '0;
      req_ch.tape_ear    = 1'b0;
      rsp_ch.ready       = 1'b0;
   end

   // Receiver: random stalls, plus a long hold-off on each request for one
   initial begin
      int hold_left;
      int seen_seq;
      hold_left = 0;
      seen_seq  = 0;
      forever begin
         @(posedge clock);
         if (holdoff_seq != seen_seq) begin
            seen_seq  = holdoff_seq;
            hold_left = HOLDOFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Abort when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   function automatic req_type make_req(input logic [1:0] cmd, input logic [15:0] addr,
                                        input logic [7:0] wval, input logic [2:0] row,
                                        input logic [2:0] col, input logic ear);
      req_type r;
      r.cmd         = cmd;
      r.address     = addr;
      r.write_value = wval;
      r.key_row     = row;
      r.key_column  = col;
      r.tape_ear    = ear;
      return r;
   endfunction

   // Random request, biased toward addresses that hit the decoders
   function automatic req_type random_request();
      req_type r;
      int      pick;
      int      kind;
      r = make_req(CMD_WRITE, 16'($urandom), 8'($urandom), 3'($urandom_range(7)),
                   ($urandom_range(9) < 8) ? 3'($urandom_range(4)) : 3'($urandom_range(7, 5)),
                   1'($urandom_range(1)));
      kind = $urandom_range(9);
      pick = $urandom_range(3);
      if (kind < 3) begin
         r.cmd = CMD_WRITE;
         case (pick)
            0: r.address[0] = 1'b0;
            1: r.address = (r.address & ~PAGING_DECODE_MASK) | 16'd1;
            2: r.address[7:0] = PORT_FF;
            default: ;
         endcase
      end else if (kind < 6) begin
         r.cmd = CMD_READ;
         case (pick)
            0: r.address[7:0] = PORT_KEYS;
            1: begin
               // select a single row
               r.address[7:0]  = PORT_KEYS;
               r.address[15:8] = ~(8'd1 << $urandom_range(7));
            end
            2: r.address[7:0] = PORT_FF;
            default: ;
         endcase
      end else if (kind < 8) begin
         r.cmd = CMD_KEY_DOWN;
      end else begin
         r.cmd = CMD_KEY_UP;
      end
      return r;
   endfunction

   // Offer one request and return at the edge where it is accepted
   task automatic send_request(input req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.cmd         <= r.cmd;
      req_ch.address     <= r.address;
      req_ch.write_value <= r.write_value;
      req_ch.key_row     <= r.key_row;
      req_ch.key_column  <= r.key_column;
      req_ch.tape_ear    <= r.tape_ear;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // Drop valid and wait until every response is back
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      req_type directed [$];
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Keyboard with every key released, ear high and low
      directed.push_back(make_req(CMD_READ,     16'hFEFE, 8'h00, 3'd0, 3'd0, 1'b1));
      directed.push_back(make_req(CMD_READ,     16'h00FE, 8'h00, 3'd0, 3'd0, 1'b0));
      // Press keys at the row and column extremes, one column out of range
      directed.push_back(make_req(CMD_KEY_DOWN, 16'h0000, 8'h00, 3'd0, 3'd0, 1'b0));
      directed.push_back(make_req(CMD_KEY_DOWN, 16'h0000, 8'h00, 3'd7, 3'd4, 1'b0));
      directed.push_back(make_req(CMD_KEY_DOWN, 16'h0000, 8'h00, 3'd3, 3'd7, 1'b0));
      directed.push_back(make_req(CMD_KEY_DOWN, 16'h0000, 8'h00, 3'd5, 3'd2, 1'b0));
      directed.push_back(make_req(CMD_READ,     16'hFEFE, 8'h00, 3'd0, 3'd0, 1'b1));
      directed.push_back(make_req(CMD_READ,     16'h7FFE, 8'h00, 3'd0, 3'd0, 1'b0));
      directed.push_back(make_req(CMD_READ,     16'h00FE, 8'h00, 3'd0, 3'd0, 1'b1));
      directed.push_back(make_req(CMD_READ,     16'hFFFE, 8'h00, 3'd0, 3'd0, 1'b0));
      // Release, again with a column beyond the row width
      directed.push_back(make_req(CMD_KEY_UP,   16'h0000, 8'h00, 3'd0, 3'd0, 1'b0));
      directed.push_back(make_req(CMD_KEY_UP,   16'h0000, 8'h00, 3'd3, 3'd5, 1'b0));
      // FE latch through all four beeper levels
      directed.push_back(make_req(CMD_WRITE,    16'h00FE, 8'h00, 3'd0, 3'd0, 1'b0));
      directed.push_back(make_req(CMD_WRITE,    16'hFFFE, 8'h08, 3'd0, 3'd0, 1'b0));
      directed.push_back(make_req(CMD_WRITE,    16'h1234, 8'h10, 3'd0, 3'd0, 1'b0));
      directed.push_back(make_req(CMD_WRITE,    16'h0000, 8'hFF, 3'd0, 3'd0, 1'b0));
      // Paging, FF latch and ignored odd addresses
      directed.push_back(make_req(CMD_WRITE,    16'h7FFD, 8'hA5, 3'd0, 3'd0, 1'b0));
      directed.push_back(make_req(CMD_WRITE,    16'h00FF, 8'h5A, 3'd0, 3'd0, 1'b0));
      directed.push_back(make_req(CMD_WRITE,    16'hFFFF, 8'hFF, 3'd0, 3'd0, 1'b0));
      directed.push_back(make_req(CMD_WRITE,    16'h8001, 8'h11, 3'd0, 3'd0, 1'b0));
      directed.push_back(make_req(CMD_WRITE,    16'h0003, 8'h22, 3'd0, 3'd0, 1'b0));
      directed.push_back(make_req(CMD_WRITE,    16'h0001, 8'h00, 3'd0, 3'd0, 1'b0));
      // Reads of the FF port and of unmapped ports
      directed.push_back(make_req(CMD_READ,     16'h00FF, 8'h00, 3'd0, 3'd0, 1'b1));
      directed.push_back(make_req(CMD_READ,     16'h1234, 8'h00, 3'd0, 3'd0, 1'b1));
      directed.push_back(make_req(CMD_READ,     16'hFFFD, 8'h00, 3'd0, 3'd0, 1'b1));
      foreach (directed[i]) send_request(directed[i]);
      wait_drained();

      // Random traffic; the first phase opens with a long receiver hold-off
      for (int p = 0; p < NUM_PHASES; p++) begin
         send_idle_pct <= SEND_IDLE_PCT[p];
         rsp_stall_pct <= RSP_STALL_PCT[p];
         if (p == 0) holdoff_seq <= holdoff_seq + 1;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) send_request(random_request());
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
